// File: rtl/pcsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG chunk stream checker package
// Shared types, constants and per-byte helper functions.
// ----------------------------------------------------------------------------
package pcsc_pkg;

  // Reflected CRC-32 polynomial and the all-ones seed / final XOR
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

  // Upper-case chunk types recognized by the walker
  localparam logic [31:0] KIND_IHDR   = 32'h4948_4452;
  localparam logic [31:0] KIND_IEND   = 32'h4945_4E44;

  // Byte counts of the fixed fields
  localparam logic [31:0] SIG_BYTES   = 32'd8;
  localparam logic [31:0] FIELD_BYTES = 32'd4;
  localparam logic [31:0] DIM_BYTES   = 32'd4;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC,
    PH_DONE
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_CHUNK = 2'd0,
    ST_IEND  = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  // One input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } item_t;

  // One result word
  typedef struct packed {
    status_t     status;
    logic [31:0] chunk_kind;
    logic [31:0] chunk_length;
    logic        crc_match;
    logic [31:0] total_bytes;
    logic [31:0] image_width;
    logic [31:0] image_height;
  } result_t;

  // One byte of the reflected CRC-32, eight bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Fold ASCII letters of each type byte to upper case
  function automatic logic [31:0] fold_kind(input logic [31:0] t);
    logic [31:0] r;
    logic [7:0]  b;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      b = t[8*i +: 8];
      if (b >= 8'h61 && b <= 8'h7A) begin
        b = b - 8'h20;
      end
      r[8*i +: 8] = b;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pcsc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG chunk stream checker channels
// Valid/ready interfaces for the byte input and the chunk result output.
// ----------------------------------------------------------------------------
interface pcsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface pcsc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] chunk_kind;
  logic [31:0] chunk_length;
  logic        crc_match;
  logic [31:0] total_bytes;
  logic [31:0] image_width;
  logic [31:0] image_height;

  modport source (output valid, output status, output chunk_kind, output chunk_length,
                  output crc_match, output total_bytes, output image_width,
                  output image_height, input ready);
  modport sink   (input valid, input status, input chunk_kind, input chunk_length,
                  input crc_match, input total_bytes, input image_width,
                  input image_height, output ready);
endinterface
`default_nettype wire

// File: rtl/pcsc_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG chunk stream checker input register
// Holds one input word; refills in the same cycle the parser takes it.
// ----------------------------------------------------------------------------
module pcsc_in_reg
  import pcsc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  pcsc_byte_if.sink   in_ch,
  output item_t       item,
  output logic        item_valid,
  input  wire logic   item_take
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ch.ready = !valid_r || item_take;
  assign item        = item_r;
  assign item_valid  = valid_r;

  // Occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.valid && in_ch.ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte   <= in_ch.data_byte;
      item_r.end_of_data <= in_ch.end_of_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pcsc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG chunk stream checker parser core
// Walks signature, length, type, data and CRC fields one byte per cycle when a byte is taken.
// ----------------------------------------------------------------------------
module pcsc_core
  import pcsc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire item_t  item,
  input  wire logic   take,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt, len_stp;
  logic [31:0] kind_r, kind_nxt, kind_stp;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] scrc_r, scrc_nxt, scrc_stp;
  logic [31:0] total_r, total_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;

  logic [7:0]  b;
  logic        last;
  logic        active;
  logic [31:0] cnt_inc;
  logic        sig_end, four_done, data_end;
  logic [31:0] kind_shift;
  logic [31:0] crc_upd;
  logic        is_ihdr, is_iend;
  logic        chunk_close;

  // Shared per-word terms
  assign b          = item.data_byte;
  assign last       = item.end_of_data;
  assign active     = take && (phase_r != PH_DONE);
  assign cnt_inc    = cnt_r + 32'd1;
  assign sig_end    = (cnt_inc == SIG_BYTES);
  assign four_done  = (cnt_inc == FIELD_BYTES);
  assign data_end   = (cnt_inc >= len_r);
  assign kind_shift = {kind_r[23:0], b};
  assign crc_upd    = crc_byte(crc_r, b);
  assign is_ihdr    = (fold_kind(kind_r) == KIND_IHDR);
  assign is_iend    = (fold_kind(kind_r) == KIND_IEND);
  assign chunk_close = active && (phase_r == PH_CRC) && four_done;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (active) begin
      unique case (phase_r)
        PH_SIG:  if (sig_end) phase_nxt = PH_LEN;
        PH_LEN:  if (four_done) phase_nxt = PH_TYPE;
        PH_TYPE: if (four_done) phase_nxt = (len_r == 32'd0) ? PH_CRC : PH_DATA;
        PH_DATA: if (data_end) phase_nxt = PH_CRC;
        PH_CRC:  if (four_done) phase_nxt = is_iend ? PH_DONE : PH_LEN;
        default: phase_nxt = phase_r;
      endcase
      if (last) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  // Field datapath
  always_comb begin
    cnt_nxt    = cnt_r;
    len_stp    = len_r;
    kind_stp   = kind_r;
    crc_nxt    = crc_r;
    scrc_stp   = scrc_r;
    total_nxt  = total_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (active) begin
      if (total_r != ALL_ONES) begin
        total_nxt = total_r + 32'd1;
      end
      cnt_nxt = cnt_inc;
      case (phase_r)
        PH_SIG: begin
          if (sig_end) cnt_nxt = '0;
        end
        PH_LEN: begin
          len_stp = {len_r[23:0], b};
          if (four_done) begin
            cnt_nxt = '0;
            crc_nxt = ALL_ONES;
          end
        end
        PH_TYPE: begin
          kind_stp = kind_shift;
          crc_nxt  = crc_upd;
          if (four_done) begin
            cnt_nxt = '0;
            if (fold_kind(kind_shift) == KIND_IHDR) begin
              width_nxt  = '0;
              height_nxt = '0;
            end
          end
        end
        PH_DATA: begin
          crc_nxt = crc_upd;
          if (is_ihdr) begin
            if (cnt_r < DIM_BYTES) begin
              width_nxt = {width_r[23:0], b};
            end else if (cnt_r < (DIM_BYTES + DIM_BYTES)) begin
              height_nxt = {height_r[23:0], b};
            end
          end
          if (data_end) cnt_nxt = '0;
        end
        PH_CRC: begin
          scrc_stp = {scrc_r[23:0], b};
          if (four_done) cnt_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // Per-chunk fields clear once the stored CRC has closed the chunk
  always_comb begin
    len_nxt  = chunk_close ? '0 : len_stp;
    kind_nxt = chunk_close ? '0 : kind_stp;
    scrc_nxt = chunk_close ? '0 : scrc_stp;
  end

  // Result word
  always_comb begin
    res_valid        = active && (chunk_close || last);
    res.chunk_kind   = kind_stp;
    res.chunk_length = len_stp;
    res.total_bytes  = total_nxt;
    res.image_width  = width_nxt;
    res.image_height = height_nxt;
    if (chunk_close) begin
      res.status    = is_iend ? ST_IEND : (last ? ST_TRUNC : ST_CHUNK);
      res.crc_match = ((crc_r ^ ALL_ONES) == scrc_stp);
    end else begin
      res.status    = ST_TRUNC;
      res.crc_match = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      cnt_r    <= '0;
      len_r    <= '0;
      kind_r   <= '0;
      crc_r    <= ALL_ONES;
      scrc_r   <= '0;
      total_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      len_r    <= len_nxt;
      kind_r   <= kind_nxt;
      crc_r    <= crc_nxt;
      scrc_r   <= scrc_nxt;
      total_r  <= total_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pcsc_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG chunk stream checker output register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module pcsc_out_reg
  import pcsc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         room,
  pcsc_result_if.source out_ch
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign room = !valid_r || out_ch.ready;

  // Occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.status       = res_r.status;
  assign out_ch.chunk_kind   = res_r.chunk_kind;
  assign out_ch.chunk_length = res_r.chunk_length;
  assign out_ch.crc_match    = res_r.crc_match;
  assign out_ch.total_bytes  = res_r.total_bytes;
  assign out_ch.image_width  = res_r.image_width;
  assign out_ch.image_height = res_r.image_height;

endmodule
`default_nettype wire

// File: rtl/png_chunk_stream_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG chunk stream checker
// Walks the chunks of a PNG byte stream, checks each CRC-32, reports chunks.
// ----------------------------------------------------------------------------
// The block takes one byte of the file per cycle, starting at the first of
// the eight signature bytes, and sustains one byte every clock as long as the
// result side keeps up. The byte that ends a chunk goes through the input register,
// the parser and the output register before its result appears; the per-cycle
// work is one byte step of the reflected CRC-32 plus the field counter. A
// word with end_of_data set that does not finish the IEND chunk yields a
// truncation result; after IEND or end of data every further byte is taken
// and dropped until reset.
module png_chunk_stream_checker
  import pcsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  pcsc_byte_if.sink      in_ch,
  pcsc_result_if.source  out_ch
);

  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    room;
  logic    res_valid;
  result_t res;

  assign item_take = item_valid && room;

  pcsc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  pcsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .take      (item_take),
    .res_valid (res_valid),
    .res       (res)
  );

  pcsc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk stream checker testbench
// Feeds one long PNG byte stream (signature, directed chunks, random chunks,
// then one randomly chosen ending and some trailing bytes) through the byte
// channel under several idle/stall mixes. A local chunk walker predicts each
// result word, which is checked field by field against the result channel.
// ----------------------------------------------------------------------------
module tb_top;
  import pcsc_pkg::*;

  // Ways the stream can end; one is picked per run
  typedef enum {
    END_IEND,
    END_IEND_LAST,
    END_IEND_BAD_CRC,
    END_CUT_AT_CHUNK,
    END_CUT_LENGTH,
    END_CUT_TYPE,
    END_CUT_DATA,
    END_CUT_CRC
  } ending_t;

  localparam int MAX_REPORTS = 10;
  localparam int PHASE_BYTES = 170;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;

  pcsc_byte_if   in_ch ();
  pcsc_result_if out_ch ();

  png_chunk_stream_checker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Byte words waiting for the driver, and chunk results still owed
  item_t       pending_bytes [$];
  result_t     expected_chunks [$];
  logic [7:0]  data_prefix [$];

  logic [7:0]  png_sig [8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
  int          idle_plan [5] = '{0, 88, 0, 9, 0};
  int          stall_plan [5] = '{0, 0, 88, 9, 0};

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          in_fire = 1'b0;
  int          error_count = 0;
  int          bytes_accepted = 0;
  int          results_checked = 0;
  ending_t     ending;

  // Chunk walker state
  phase_t      walk_phase = PH_SIG;
  logic [31:0] walk_count = '0;
  logic [31:0] cur_length = '0;
  logic [31:0] cur_kind = '0;
  logic [31:0] crc_acc = ALL_ONES;
  logic [31:0] crc_stored = '0;
  logic [31:0] bytes_seen = '0;
  logic [31:0] img_width = '0;
  logic [31:0] img_height = '0;

  // Reflected CRC-32, one data bit per step, LSB first
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    int k;
    r = acc;
    for (k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // Upper-case the letters of a chunk type, other bytes unchanged
  function automatic logic [31:0] fold_upper(input logic [31:0] t);
    logic [31:0] r;
    logic [7:0]  c;
    int k;
    r = '0;
    for (k = 3; k >= 0; k--) begin
      c = t[8*k +: 8];
      if (c >= 8'h61 && c <= 8'h7A) begin
        c = c & 8'hDF;
      end
      r = {r[23:0], c};
    end
    return r;
  endfunction

  function automatic result_t pack_result(input status_t st, input bit match);
    result_t r;
    r.status       = st;
    r.chunk_kind   = cur_kind;
    r.chunk_length = cur_length;
    r.crc_match    = match;
    r.total_bytes  = bytes_seen;
    r.image_width  = img_width;
    r.image_height = img_height;
    return r;
  endfunction

  // Advance the walker by one byte; returns 1 when a result word is due
  function automatic bit walk_byte(input logic [7:0] b, input logic last, output result_t res);
    bit      is_end;
    status_t st;
    res = '0;
    if (walk_phase == PH_DONE) begin
      return 1'b0;
    end
    if (bytes_seen != ALL_ONES) begin
      bytes_seen++;
    end
    case (walk_phase)
      PH_SIG: begin
        walk_count++;
        if (walk_count >= SIG_BYTES) begin
          walk_count = '0;
          walk_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        cur_length = {cur_length[23:0], b};
        walk_count++;
        if (walk_count >= FIELD_BYTES) begin
          walk_count = '0;
          crc_acc    = ALL_ONES;
          walk_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        cur_kind = {cur_kind[23:0], b};
        crc_acc  = crc32_step(crc_acc, b);
        walk_count++;
        if (walk_count >= FIELD_BYTES) begin
          walk_count = '0;
          if (fold_upper(cur_kind) == KIND_IHDR) begin
            img_width  = '0;
            img_height = '0;
          end
          walk_phase = (cur_length == 0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_acc = crc32_step(crc_acc, b);
        // IHDR payload: first four bytes width, next four height
        if (fold_upper(cur_kind) == KIND_IHDR) begin
          if (walk_count < DIM_BYTES) begin
            img_width = {img_width[23:0], b};
          end else if (walk_count < 2 * DIM_BYTES) begin
            img_height = {img_height[23:0], b};
          end
        end
        walk_count++;
        if (walk_count >= cur_length) begin
          walk_count = '0;
          walk_phase = PH_CRC;
        end
      end
      default: begin
        crc_stored = {crc_stored[23:0], b};
        walk_count++;
        if (walk_count >= FIELD_BYTES) begin
          is_end = (fold_upper(cur_kind) == KIND_IEND);
          if (is_end) begin
            st = ST_IEND;
          end else if (last) begin
            st = ST_TRUNC;
          end else begin
            st = ST_CHUNK;
          end
          res = pack_result(st, (crc_acc ^ ALL_ONES) == crc_stored);
          walk_count = '0;
          if (is_end || last) begin
            walk_phase = PH_DONE;
          end else begin
            walk_phase = PH_LEN;
            cur_length = '0;
            cur_kind   = '0;
            crc_stored = '0;
          end
          return 1'b1;
        end
      end
    endcase
    // Data ran out in the middle of a chunk
    if (last) begin
      res = pack_result(ST_TRUNC, 1'b0);
      walk_phase = PH_DONE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Random chunk type that never folds to IEND; letters get random case
  function automatic logic [31:0] pick_kind();
    logic [31:0] k;
    logic [31:0] src;
    logic [7:0]  c;
    int sel;
    int i;
    k = '0;
    do begin
      sel = $urandom_range(0, 5);
      for (i = 0; i < 4; i++) begin
        if (sel == 0) begin
          src = KIND_IHDR >> (24 - 8 * i);
          c = src[7:0];
        end else if (sel <= 2) begin
          c = 8'h41 + 8'($urandom_range(0, 25));
        end else begin
          c = 8'($urandom_range(0, 255));
        end
        if (sel <= 2 && c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) begin
          c = c + 8'h20;
        end
        k = {k[23:0], c};
      end
    end while (fold_upper(k) == KIND_IEND);
    return k;
  endfunction

  // Queue one chunk; cut >= 0 sends only that many of its bytes.
  // Data bytes come from data_prefix first, then random.
  task automatic queue_chunk(input logic [31:0] len, input logic [31:0] kind,
                             input bit corrupt, input int cut, input bit eod_last);
    logic [31:0]     crc;
    logic [31:0]     stored;
    logic [31:0]     word;
    longint unsigned n_emit;
    longint unsigned idx;
    item_t           it;
    crc    = ALL_ONES;
    stored = '0;
    n_emit = (cut < 0) ? (64'(len) + 64'd12) : longint'(cut);
    for (idx = 0; idx < n_emit; idx++) begin
      if (idx < 4) begin
        word = len >> (24 - 8 * idx);
      end else if (idx < 8) begin
        word = kind >> (24 - 8 * (idx - 4));
        crc  = crc32_step(crc, word[7:0]);
      end else if (idx < 8 + 64'(len)) begin
        word = (data_prefix.size() > 0) ? {24'd0, data_prefix.pop_front()}
                                        : $urandom_range(0, 255);
        crc  = crc32_step(crc, word[7:0]);
      end else begin
        if (idx == 8 + 64'(len)) begin
          stored = ~crc;
          if (corrupt) begin
            stored = stored ^ (32'h1 << $urandom_range(0, 31));
          end
        end
        word = stored >> (24 - 8 * (idx - 8 - 64'(len)));
      end
      it.data_byte   = word[7:0];
      it.end_of_data = eod_last && (idx == n_emit - 1);
      pending_bytes.push_back(it);
    end
  endtask

  // Wait until every queued word is taken and every result has come back
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_ch.valid) begin
      @(posedge clk);
    end
    while (expected_chunks.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
    if (seen !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, name, want, seen);
      end
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Byte driver: new word at the falling edge once the last one is taken
  always @(negedge clk) begin : drive_bytes
    item_t next_item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_item = pending_bytes.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= next_item.data_byte;
        in_ch.end_of_data <= next_item.end_of_data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: predict on accepted bytes, check accepted results
  always @(posedge clk) begin : watch_ports
    result_t want;
    result_t seen;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      bytes_accepted++;
      if (walk_byte(in_ch.data_byte, in_ch.end_of_data, want)) begin
        expected_chunks.push_back(want);
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.status       = status_t'(out_ch.status);
      seen.chunk_kind   = out_ch.chunk_kind;
      seen.chunk_length = out_ch.chunk_length;
      seen.crc_match    = out_ch.crc_match;
      seen.total_bytes  = out_ch.total_bytes;
      seen.image_width  = out_ch.image_width;
      seen.image_height = out_ch.image_height;
      if (expected_chunks.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("[%0t] result word with none expected: kind %h length %h",
                   $realtime, seen.chunk_kind, seen.chunk_length);
        end
      end else begin
        want = expected_chunks.pop_front();
        results_checked++;
        compare_field("status", 32'(want.status), 32'(seen.status));
        compare_field("chunk_kind", want.chunk_kind, seen.chunk_kind);
        compare_field("chunk_length", want.chunk_length, seen.chunk_length);
        compare_field("crc_match", 32'(want.crc_match), 32'(seen.crc_match));
        compare_field("total_bytes", want.total_bytes, seen.total_bytes);
        compare_field("image_width", want.image_width, seen.image_width);
        compare_field("image_height", want.image_height, seen.image_height);
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [31:0] kind;
    logic [31:0] len;
    item_t       it;
    int          r;
    int          m;
    int          i;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.end_of_data  = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: signature, mixed-case IHDR with extreme dimensions,
    // empty chunk with extreme type bytes and a broken CRC
    for (i = 0; i < 8; i++) begin
      it.data_byte   = png_sig[i];
      it.end_of_data = 1'b0;
      pending_bytes.push_back(it);
    end
    data_prefix = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    queue_chunk(32'd8, 32'h6948_6452, 1'b0, -1, 1'b0);
    queue_chunk(32'd0, 32'hFF00_FF00, 1'b1, -1, 1'b0);
    // Sender holds off here until every result is back
    wait_drained();

    // Random chunks under each idle/stall mix
    for (m = 0; m < 5; m++) begin
      send_idle_pct  = idle_plan[m];
      recv_stall_pct = stall_plan[m];
      while (pending_bytes.size() < PHASE_BYTES) begin
        kind = pick_kind();
        if (fold_upper(kind) == KIND_IHDR) begin
          len = $urandom_range(0, 13);
        end else begin
          r = $urandom_range(0, 9);
          if (r < 6) begin
            len = $urandom_range(0, 8);
          end else if (r < 9) begin
            len = $urandom_range(9, 20);
          end else begin
            len = $urandom_range(21, 48);
          end
        end
        queue_chunk(len, kind, $urandom_range(0, 7) == 0, -1, 1'b0);
      end
      wait_drained();
    end

    // One ending per run, then bytes the block must drop
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    ending = ending_t'($urandom_range(0, 7));
    case (ending)
      END_IEND:         queue_chunk(32'd0, KIND_IEND, 1'b0, -1, 1'b0);
      END_IEND_LAST:    queue_chunk($urandom_range(1, 4), 32'h6945_6E44, 1'b0, -1, 1'b1);
      END_IEND_BAD_CRC: queue_chunk(32'd0, 32'h4965_4E64, 1'b1, -1, 1'b0);
      END_CUT_AT_CHUNK: queue_chunk($urandom_range(0, 6), pick_kind(),
                                    $urandom_range(0, 1) == 1, -1, 1'b1);
      END_CUT_LENGTH:   queue_chunk(ALL_ONES, pick_kind(), 1'b0, $urandom_range(1, 4), 1'b1);
      END_CUT_TYPE:     queue_chunk(($urandom_range(0, 1) == 1) ? ALL_ONES : 32'd0,
                                    pick_kind(), 1'b0, $urandom_range(5, 8), 1'b1);
      END_CUT_DATA: begin
        kind = ($urandom_range(0, 1) == 1) ? KIND_IHDR : pick_kind();
        queue_chunk(($urandom_range(0, 1) == 1) ? ALL_ONES : 32'h8000_0000,
                    kind, 1'b0, $urandom_range(9, 20), 1'b1);
      end
      default: begin
        len  = $urandom_range(0, 4);
        kind = ($urandom_range(0, 1) == 1) ? KIND_IEND : pick_kind();
        queue_chunk(len, kind, 1'b0, 8 + len + $urandom_range(1, 3), 1'b1);
      end
    endcase
    r = $urandom_range(4, 10);
    for (i = 0; i < r; i++) begin
      it.data_byte   = 8'($urandom_range(0, 255));
      it.end_of_data = 1'($urandom_range(0, 1));
      pending_bytes.push_back(it);
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes and %0d chunk results, ending with %s.",
             bytes_accepted, results_checked, ending.name());
    $display("Errors counted: %0d, results still owed: %0d",
             error_count, expected_chunks.size());
    if (error_count == 0 && expected_chunks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still owed", expected_chunks.size());
    $display("Verification failed");
    $finish;
  end

endmodule
